>>> rtl/csvtok_pkg.sv
`timescale 1ns / 1ps
// csv row field tokenizer: shared types, codes and character constants
// no dependencies; used by the controller, the datapath and the top level

package csvtok_pkg;

	// characters with a meaning to the parser
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// width of the column count register
	localparam int NUM_COL_W = 6;

	// field parser mode
	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_PLAIN  = 2'd1,
		MODE_QUOTED = 2'd2,
		MODE_AFTERQ = 2'd3
	} parse_mode_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CR,
		ST_BYTE,
		ST_ROW_FIRST,
		ST_ROW_PAD
	} ctl_state_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_CR,
		OP_BYTE,
		OP_ROW_FIRST,
		OP_ROW_PAD
	} dp_op_t;

	// one result beat without its run marker
	typedef struct packed {
		logic [7:0] char_byte;
		logic       is_char;
		logic       field_done;
		logic       field_null;
		logic [4:0] column;
		logic       row_done;
	} result_t;

	// controller to datapath
	typedef struct packed {
		dp_op_t op;
		logic   accept;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_cr_take;
		logic in_byte_take;
		logic in_row_end;
		logic byte_take;
		logic row_end;
		logic go;
		logic split;
		logic row_fin;
		logic flush_ok;
	} dp_status_t;

endpackage

>>> rtl/csvtok_in_if.sv
`timescale 1ns / 1ps
// csv row field tokenizer: input byte channel
// valid/ready handshake with the byte and the end-of-data flag

interface csvtok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

>>> rtl/csvtok_out_if.sv
`timescale 1ns / 1ps
// csv row field tokenizer: result channel
// valid/ready handshake with one field content byte or field close per beat

interface csvtok_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       is_char;
	logic       field_done;
	logic       field_null;
	logic [4:0] column;
	logic       row_done;
	logic       last_of_run;

	modport source (output valid, output char_byte, output is_char, output field_done,
		output field_null, output column, output row_done, output last_of_run,
		input ready);
	modport sink (input valid, input char_byte, input is_char, input field_done,
		input field_null, input column, input row_done, input last_of_run,
		output ready);
endinterface

>>> rtl/csvtok_dp.sv
`timescale 1ns / 1ps
// csv row field tokenizer datapath: parser state, column counter, result hold and output
// depends on csvtok_pkg and csvtok_out_if; driven by csvtok_ctrl commands

module csvtok_dp import csvtok_pkg::*; #(
	parameter int MAX_COLUMNS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [NUM_COL_W-1:0] cfg_wr_data,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_data,
	input  dp_cmd_t              cmd,
	output dp_status_t           sts,
	csvtok_out_if.source         tx
);

	localparam int CW = $clog2(MAX_COLUMNS + 1);

	logic [NUM_COL_W-1:0] num_q;
	parse_mode_t          mode_q, mode_d;
	logic                 crp_q;
	logic                 rstart_q, rs_d;
	logic                 nonempty_q, ne_d;
	logic [CW-1:0]        col_q, col_d;
	logic                 byte_take_q, row_end_q;
	logic [7:0]           byte_q;
	result_t              h_q, out_q, res;
	logic                 h_v_q, out_v_q, out_last_q;

	logic [CW-1:0] nc, c_sel;
	logic [CW:0]   nc_x, col_inc, c_inc;
	logic [7:0]    tb;
	logic          tq, tc, col_lt_nc;
	logic          emit, split, fin_row, do_put, do_end;
	logic          work, go, slot_free, push_h, move_out, flush;

	// clamp the column count to 1..MAX_COLUMNS
	always_comb begin
		if (num_q == '0)
			nc = CW'(1);
		else if ({1'b0, num_q} > (NUM_COL_W + 1)'(MAX_COLUMNS))
			nc = CW'(MAX_COLUMNS);
		else
			nc = CW'(num_q);
	end

	assign nc_x      = {1'b0, nc};
	assign col_inc   = {1'b0, col_q} + (CW + 1)'(1);
	assign col_lt_nc = (col_q < nc);
	assign c_sel     = col_lt_nc ? col_q : (nc - CW'(1));
	assign c_inc     = {1'b0, c_sel} + (CW + 1)'(1);

	// byte under work: the held carriage return or the latched byte
	assign tb = (cmd.op == OP_CR) ? CH_CR : byte_q;
	assign tq = (tb == CH_QUOTE);
	assign tc = (tb == CH_COMMA);

	// one parser step: at most one result per cycle
	always_comb begin
		res     = '0;
		emit    = 1'b0;
		split   = 1'b0;
		fin_row = 1'b0;
		do_put  = 1'b0;
		do_end  = 1'b0;
		mode_d  = mode_q;
		rs_d    = rstart_q;
		ne_d    = nonempty_q;
		col_d   = col_q;
		case (cmd.op)
			OP_CR, OP_BYTE: begin
				rs_d = 1'b1;
				case (mode_q)
					MODE_START: begin
						if (tq) begin
							mode_d = MODE_QUOTED;
						end else if (tc) begin
							do_end = 1'b1;
						end else begin
							do_put = 1'b1;
							mode_d = MODE_PLAIN;
						end
					end
					MODE_PLAIN: begin
						if (tc)
							do_end = 1'b1;
						else
							do_put = 1'b1;
					end
					MODE_QUOTED: begin
						if (tq)
							mode_d = MODE_AFTERQ;
						else
							do_put = 1'b1;
					end
					MODE_AFTERQ: begin
						if (tq) begin
							do_put = 1'b1;
							mode_d = MODE_QUOTED;
						end else begin
							// other byte: close now; a byte other than a comma then starts a plain field
							do_end = 1'b1;
							split  = !tc;
						end
					end
					default: ;
				endcase
				if (do_put && col_lt_nc) begin
					emit          = 1'b1;
					res.char_byte = tb;
					res.is_char   = 1'b1;
					res.column    = 5'(col_q);
					ne_d          = 1'b1;
				end
				if (do_end) begin
					mode_d = MODE_START;
					if (col_inc < nc_x) begin
						emit           = 1'b1;
						res.field_done = 1'b1;
						res.field_null = !nonempty_q;
						res.column     = 5'(col_q);
						col_d          = col_inc[CW-1:0];
						ne_d           = 1'b0;
					end else begin
						col_d = nc;
					end
				end
			end
			OP_ROW_FIRST: begin
				if (rstart_q) begin
					emit           = 1'b1;
					res.field_done = 1'b1;
					res.field_null = !nonempty_q;
					res.column     = 5'(c_sel);
					res.row_done   = (c_inc >= nc_x);
					fin_row        = (c_inc >= nc_x);
					col_d          = c_inc[CW-1:0];
				end else begin
					fin_row = 1'b1;
				end
			end
			OP_ROW_PAD: begin
				emit           = 1'b1;
				res.field_done = 1'b1;
				res.field_null = 1'b1;
				res.column     = 5'(col_q);
				res.row_done   = (col_inc >= nc_x);
				fin_row        = (col_inc >= nc_x);
				col_d          = col_inc[CW-1:0];
			end
			default: ;
		endcase
		if (fin_row) begin
			mode_d = MODE_START;
			rs_d   = 1'b0;
			ne_d   = 1'b0;
			col_d  = '0;
		end
	end

	// hold and output slot control
	assign slot_free = !out_v_q || tx.ready;
	assign work      = (cmd.op != OP_IDLE);
	assign go        = !(emit && h_v_q) || slot_free;
	assign push_h    = work && go && emit;
	assign move_out  = push_h && h_v_q;
	assign flush     = (cmd.op == OP_IDLE) && h_v_q && slot_free;

	// status to the controller
	always_comb begin
		sts.in_cr_take   = crp_q && (data_byte != CH_LF);
		sts.in_byte_take = (data_byte != CH_LF) && (data_byte != CH_CR);
		sts.in_row_end   = (data_byte == CH_LF) || end_of_data;
		sts.byte_take    = byte_take_q;
		sts.row_end      = row_end_q;
		sts.go           = go;
		sts.split        = split;
		sts.row_fin      = fin_row;
		sts.flush_ok     = !h_v_q || slot_free;
	end

	// control and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q       <= NUM_COL_W'(1);
			mode_q      <= MODE_START;
			crp_q       <= 1'b0;
			rstart_q    <= 1'b0;
			nonempty_q  <= 1'b0;
			col_q       <= '0;
			byte_take_q <= 1'b0;
			row_end_q   <= 1'b0;
			h_v_q       <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (cfg_wr_en)
				num_q <= cfg_wr_data;
			if (cmd.accept) begin
				crp_q       <= (data_byte == CH_CR) && !end_of_data;
				byte_take_q <= sts.in_byte_take;
				row_end_q   <= sts.in_row_end;
			end
			if (work && go) begin
				mode_q     <= mode_d;
				rstart_q   <= rs_d;
				nonempty_q <= ne_d;
				col_q      <= col_d;
			end
			if (push_h)
				h_v_q <= 1'b1;
			else if (flush)
				h_v_q <= 1'b0;
			if (move_out || flush)
				out_v_q <= 1'b1;
			else if (tx.ready)
				out_v_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept)
			byte_q <= data_byte;
		if (push_h)
			h_q <= res;
		if (move_out || flush) begin
			out_q      <= h_q;
			out_last_q <= flush;
		end
	end

	// result channel
	assign tx.valid       = out_v_q;
	assign tx.char_byte   = out_q.char_byte;
	assign tx.is_char     = out_q.is_char;
	assign tx.field_done  = out_q.field_done;
	assign tx.field_null  = out_q.field_null;
	assign tx.column      = out_q.column;
	assign tx.row_done    = out_q.row_done;
	assign tx.last_of_run = out_last_q;

endmodule

>>> rtl/csvtok_ctrl.sv
`timescale 1ns / 1ps
// csv row field tokenizer controller: sequences the steps for one input beat
// depends on csvtok_pkg; commands csvtok_dp

module csvtok_ctrl import csvtok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  dp_status_t sts,
	output dp_cmd_t    cmd
);

	ctl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		rx_ready   = 1'b0;
		cmd.op     = OP_IDLE;
		cmd.accept = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rx_ready   = sts.flush_ok;
				cmd.accept = sts.flush_ok && rx_valid;
				if (cmd.accept) begin
					if (sts.in_cr_take)
						state_d = ST_CR;
					else if (sts.in_byte_take)
						state_d = ST_BYTE;
					else if (sts.in_row_end)
						state_d = ST_ROW_FIRST;
				end
			end
			ST_CR: begin
				cmd.op = OP_CR;
				if (sts.go && !sts.split) begin
					if (sts.byte_take)
						state_d = ST_BYTE;
					else if (sts.row_end)
						state_d = ST_ROW_FIRST;
					else
						state_d = ST_IDLE;
				end
			end
			ST_BYTE: begin
				cmd.op = OP_BYTE;
				if (sts.go && !sts.split)
					state_d = sts.row_end ? ST_ROW_FIRST : ST_IDLE;
			end
			ST_ROW_FIRST: begin
				cmd.op = OP_ROW_FIRST;
				if (sts.go)
					state_d = sts.row_fin ? ST_IDLE : ST_ROW_PAD;
			end
			ST_ROW_PAD: begin
				cmd.op = OP_ROW_PAD;
				if (sts.go && sts.row_fin)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/csv_row_field_tokenizer.sv
`timescale 1ns / 1ps
// csv row field tokenizer top level: controller plus datapath
// depends on csvtok_pkg, csvtok_in_if, csvtok_out_if, csvtok_ctrl, csvtok_dp
//
//   channel | dir | carries
//   rx      | in  | data_byte, end_of_data
//   tx      | out | char_byte, is_char, field_done, field_null, column, row_done, last_of_run
//   cfg     | in  | cfg_wr_en, cfg_wr_data (num_columns)
//
// a beat is taken in the idle cycle, then one parser step runs per cycle:
// a held carriage return is worked before an ordinary byte, and a byte
// after a closing quote is worked again when it opens a plain field; a row
// end closes the open field of a started row, then pads each missing column. the controller sets this order.
// results wait in a hold register and an output register; tx stalls
// hold the sequencer. arst_n clears all control state, no clearing pass.

module csv_row_field_tokenizer import csvtok_pkg::*; #(
	parameter int MAX_COLUMNS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [NUM_COL_W-1:0] cfg_wr_data,
	csvtok_in_if.sink            rx,
	csvtok_out_if.source         tx
);

	dp_cmd_t    cmd;
	dp_status_t sts;

	// step sequencer
	csvtok_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// parser state and result path
	csvtok_dp #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.data_byte   (rx.data_byte),
		.end_of_data (rx.end_of_data),
		.cmd         (cmd),
		.sts         (sts),
		.tx          (tx)
	);

endmodule

>>> rtl/csvtok_checker.sv
`timescale 1ns / 1ps
// csv row field tokenizer port checker and its bind to the top level
// depends only on the top level's ports

module csvtok_checker (
	input logic clk,
	input logic arst_n,
	input logic tx_valid,
	input logic tx_ready,
	input logic tx_is_char,
	input logic tx_field_done,
	input logic tx_field_null,
	input logic tx_row_done
);

	// a stalled result beat stays offered
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid)
		else $error("result beat dropped while stalled");

	// a beat is never both a content byte and a field close
	a_char_or_close: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid |-> !(tx_is_char && tx_field_done))
		else $error("content byte and field close on one beat");

	// null flag only on a field close
	a_null_close: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_field_null |-> tx_field_done)
		else $error("null flag without field close");

	// row end only on a field close
	a_row_close: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_row_done |-> tx_field_done)
		else $error("row end without field close");

endmodule

bind csv_row_field_tokenizer csvtok_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.tx_valid      (tx.valid),
	.tx_ready      (tx.ready),
	.tx_is_char    (tx.is_char),
	.tx_field_done (tx.field_done),
	.tx_field_null (tx.field_null),
	.tx_row_done   (tx.row_done)
);
